// ----- hdl/asert_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the next-target retarget pipeline.
// No dependencies; imported by asert_fdiv and asert_next_target.
package asert_pkg;

  localparam int TargetWidth = 256;
  localparam int LimbCount   = TargetWidth / 32;
  // quotient bits of the floor divider (magnitude of err * 2^16)
  localparam int DivSteps    = 57;

  // cubic coefficients for 2^x, x in 0.16 fixed point
  localparam logic [47:0] PolyC1    = 48'd195766423245049;
  localparam logic [29:0] PolyC2    = 30'd971821376;
  localparam logic [12:0] PolyC3    = 13'd5127;
  localparam logic [63:0] PolyRound = 64'h0000_8000_0000_0000;
  localparam logic [16:0] FactorOne = 17'h1_0000;

  // compact form of a target of one
  localparam logic [31:0] CompactOne = 32'h0101_0000;

  typedef enum logic [2:0] {
    CFG_GENESIS_BITS    = 3'd0,
    CFG_TARGET_SPACING  = 3'd1,
    CFG_HALF_LIFE       = 3'd2,
    CFG_LIMIT_ZERO_BITS = 3'd3,
    CFG_HOLD_TARGET     = 3'd4
  } cfg_idx_t;

  // word entering the divider
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [DivSteps-1:0] mag;
    logic [31:0]         last_bits;
  } div_in_t;

  // word leaving the divider
  typedef struct packed {
    logic              valid;
    logic [DivSteps:0] expo;
    logic [31:0]       last_bits;
  } div_out_t;

endpackage

// ----- hdl/asert_fdiv.sv -----
`timescale 1ns / 1ps
// Pipelined floor divider: one restoring quotient bit per register stage.
// Depends on asert_pkg.
module asert_fdiv
  import asert_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  div_in_t     din,
  input  logic [31:0] dvsr,
  output div_out_t    dout
);

  logic [DivSteps-1:0] vld;
  logic [DivSteps-1:0] neg;
  logic [31:0]         rem     [DivSteps];
  logic [DivSteps-1:0] nq      [DivSteps];
  logic [31:0]         lb      [DivSteps];
  logic [31:0]         rem_in  [DivSteps];
  logic [DivSteps-1:0] nq_in   [DivSteps];
  logic [32:0]         trial   [DivSteps];
  logic                ge      [DivSteps];
  logic [31:0]         rem_next[DivSteps];
  logic [DivSteps-1:0] nq_next [DivSteps];

  // one trial subtract per stage; quotient bits shift in behind the dividend
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      rem_in[k]   = (k == 0) ? 32'd0 : rem[(k == 0) ? 0 : k - 1];
      nq_in[k]    = (k == 0) ? din.mag : nq[(k == 0) ? 0 : k - 1];
      trial[k]    = {rem_in[k], nq_in[k][DivSteps-1]};
      ge[k]       = trial[k] >= {1'b0, dvsr};
      rem_next[k] = ge[k] ? 32'(trial[k] - {1'b0, dvsr}) : trial[k][31:0];
      nq_next[k]  = {nq_in[k][DivSteps-2:0], ge[k]};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DivSteps-2:0], din.valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DivSteps; k++) begin
        rem[k] <= rem_next[k];
        nq[k]  <= nq_next[k];
      end
      neg <= {neg[DivSteps-2:0], din.neg};
      lb[0] <= din.last_bits;
      for (int k = 1; k < DivSteps; k++) begin
        lb[k] <= lb[k-1];
      end
    end
  end

  // negative dividends were complemented going in; complement back = floor
  assign dout.valid     = vld[DivSteps-1];
  assign dout.expo      = neg[DivSteps-1] ? ~{1'b0, nq[DivSteps-1]} : {1'b0, nq[DivSteps-1]};
  assign dout.last_bits = lb[DivSteps-1];

endmodule

// ----- hdl/asert_next_target.sv -----
`timescale 1ns / 1ps
// Next-target retarget pipeline: schedule error, floor divide, 2^x cubic,
// wide multiply, shift, clamp and compact encode. Depends on asert_pkg, asert_fdiv.
//
//  channel | signals                                   | flow
//  --------+-------------------------------------------+-----------------
//  request | in_valid, in_stall, last_height,          | into block
//          | elapsed_time, last_bits                   |
//  result  | out_valid, out_stall, next_bits           | out of block
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// One word is taken per cycle while the result side is not stalled; its result word is
// valid after the 57-stage divider and the polynomial, multiply, shift and encode stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled result halts the whole pipeline; nothing is dropped or repeated.
// Configuration is written with cfg_ready always high.
module asert_next_target
  import asert_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        last_height,
  input  logic signed [40:0] elapsed_time,
  input  logic [31:0]        last_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        next_bits,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers
  logic [31:0] genesis_bits;
  logic [15:0] target_spacing;
  logic [31:0] half_life;
  logic [7:0]  limit_zero_bits;
  logic        hold_target;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      genesis_bits    <= 32'h1d00_ffff;
      target_spacing  <= 16'd300;
      half_life       <= 32'd7200;
      limit_zero_bits <= 8'd32;
      hold_target     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GENESIS_BITS:    genesis_bits    <= cfg_data;
        CFG_TARGET_SPACING:  target_spacing  <= cfg_data[15:0];
        CFG_HALF_LIFE:       half_life       <= cfg_data;
        CFG_LIMIT_ZERO_BITS: limit_zero_bits <= cfg_data[7:0];
        CFG_HOLD_TARGET:     hold_target     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived constants: decoded genesis target >> 16, and the limit
  logic [7:0]             g_size;
  logic [TargetWidth-1:0] g_word;
  logic [10:0]            g_lsh;
  logic [4:0]             g_rsh;
  logic [TargetWidth-1:0] g_dec;
  logic [TargetWidth-1:0] base_q;
  logic [TargetWidth-1:0] limit_q;
  logic [31:0]            dvsr;

  always_comb begin
    g_size = genesis_bits[31:24];
    g_word = {233'd0, genesis_bits[22:0]};
    g_lsh  = {g_size, 3'b000} - 11'd24;
    g_rsh  = {2'(2'd3 - g_size[1:0]), 3'b000};
    if (g_size <= 8'd3) begin
      g_dec = g_word >> g_rsh;
    end else if (g_lsh >= 11'd256) begin
      g_dec = '0;
    end else begin
      g_dec = g_word << g_lsh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    base_q  <= g_dec >> 16;
    limit_q <= {TargetWidth{1'b1}} >> limit_zero_bits;
  end

  assign dvsr = (half_life == 32'd0) ? 32'd1 : half_life;

  // pipeline advance
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage registers
  logic v0, v1, vp1, vp2, vp3, vp4, vm1, vm2, vh1, vh2, vh3, ve1, ve2, ve3;
  logic [23:0]        h0;
  logic signed [40:0] e0, e1;
  logic [31:0]        lb0, lb1, lbp1, lbp2, lbp3, lbp4, lbm1, lbm2;
  logic [31:0]        lbh1, lbh2, lbh3, lbe1, lbe2, lbe3;
  logic [39:0]        hs1;
  logic [15:0]        f1;
  logic [41:0]        sh1, sh2, sh3, sh4;
  logic [31:0]        fsq1;
  logic [63:0]        t1_1, t1_2, t1_3, t2_2, t2_3, t3_3;
  logic [47:0]        fcu2;
  logic [16:0]        factor4;
  logic [48:0]        pp [LimbCount];
  logic               rbig_m1, rbig_m2, rbig_h1, rbig_h2, rbig_h3, rbig_e1, rbig_e2, rbig_e3;
  logic               lbig_m1, lbig_m2, lbig_h1;
  logic               neg_m1, neg_m2, neg_h1;
  logic [7:0]         sa_m1, sa_m2;
  logic [TargetWidth-1:0] prod_m2, prod_h1, tshr_h1, tshl_h1, lsh_h1, tgt_h2, tgt_h3, tgt_e1, tgt_e2;
  logic [LimbCount-1:0]   nz_e1;
  logic [4:0]             pos_e1 [LimbCount];
  logic [5:0]             size_e2, size_e3;
  logic [23:0]            c_e3;

  // error and divider feed
  logic [41:0]         err;
  logic [57:0]         num;
  div_in_t             din;
  div_out_t            dout;

  always_comb begin
    err           = {e1[40], e1} - {2'b00, hs1};
    num           = {err, 16'd0};
    din.valid     = v1;
    din.neg       = err[41];
    din.mag       = err[41] ? ~num[DivSteps-1:0] : num[DivSteps-1:0];
    din.last_bits = lb1;
  end

  asert_fdiv u_fdiv (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (din),
    .dvsr (dvsr),
    .dout (dout)
  );

  // shift amount and range flags from the integer part of the exponent
  logic        sneg4;
  logic [41:0] smag4;
  always_comb begin
    sneg4 = sh4[41];
    smag4 = sneg4 ? 42'(~sh4 + 42'd1) : sh4;
  end

  // wide product as even and odd partial-product rows
  logic [319:0] row_even, row_odd;
  always_comb begin
    row_even = '0;
    row_odd  = '0;
    for (int i = 0; i < LimbCount; i += 2) begin
      row_even[32*i +: 49]     = pp[i];
      row_odd[32*i + 32 +: 49] = pp[i+1];
    end
  end

  // leading-one position of the top nonzero limb
  logic [4:0] pos_c [LimbCount];
  logic [8:0] nbits;
  always_comb begin
    for (int i = 0; i < LimbCount; i++) begin
      pos_c[i] = 5'd0;
      for (int b = 0; b < 32; b++) begin
        if (tgt_h3[32*i + b]) pos_c[i] = 5'(b);
      end
    end
    nbits = 9'd0;
    for (int i = 0; i < LimbCount; i++) begin
      if (nz_e1[i]) nbits = {4'(i), pos_e1[i]} + 9'd1;
    end
  end

  // mantissa extraction
  logic [23:0] c_pick;
  always_comb begin
    if (size_e2 <= 6'd3) begin
      c_pick = 24'(tgt_e2[23:0] << {2'(2'd3 - size_e2[1:0]), 3'b000});
    end else begin
      c_pick = 24'(tgt_e2 >> {5'(size_e2 - 6'd3), 3'b000});
    end
  end

  // final normalise, or the held last_bits or a target of one
  logic [7:0]  size_fin;
  logic [23:0] c_fin;
  logic [31:0] bits_fin;
  always_comb begin
    size_fin = {2'b00, size_e3} + {7'd0, c_e3[23]};
    c_fin    = c_e3[23] ? {8'd0, c_e3[23:8]} : c_e3;
    if (hold_target) begin
      bits_fin = lbe3;
    end else if (rbig_e3) begin
      bits_fin = CompactOne;
    end else begin
      bits_fin = {size_fin, c_fin};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, vp1, vp2, vp3, vp4, vm1, vm2, vh1, vh2, vh3, ve1, ve2, ve3} <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0  <= in_valid;
      v1  <= v0;
      vp1 <= dout.valid;
      vp2 <= vp1;
      vp3 <= vp2;
      vp4 <= vp3;
      vm1 <= vp4;
      vm2 <= vm1;
      vh1 <= vm2;
      vh2 <= vh1;
      vh3 <= vh2;
      ve1 <= vh3;
      ve2 <= ve1;
      ve3 <= ve2;
      out_valid <= ve3;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // request capture, then height * spacing
      h0   <= last_height;
      e0   <= elapsed_time;
      lb0  <= last_bits;
      hs1  <= 40'(h0 * target_spacing);
      e1   <= e0;
      lb1  <= lb0;
      // polynomial
      f1   <= dout.expo[15:0];
      sh1  <= dout.expo[57:16];
      fsq1 <= 32'(dout.expo[15:0] * dout.expo[15:0]);
      t1_1 <= 64'(PolyC1 * dout.expo[15:0]);
      lbp1 <= dout.last_bits;
      fcu2 <= 48'(fsq1 * f1);
      t2_2 <= 64'(PolyC2 * fsq1);
      t1_2 <= t1_1;
      sh2  <= sh1;
      lbp2 <= lbp1;
      t3_3 <= 64'(PolyC3 * fcu2);
      t2_3 <= t2_2;
      t1_3 <= t1_2;
      sh3  <= sh2;
      lbp3 <= lbp2;
      factor4 <= FactorOne + {1'b0, 16'((t1_3 + t2_3 + t3_3 + PolyRound) >> 48)};
      sh4  <= sh3;
      lbp4 <= lbp3;
      // wide multiply
      for (int i = 0; i < LimbCount; i++) begin
        pp[i] <= 49'(base_q[32*i +: 32] * factor4);
      end
      rbig_m1 <= sneg4 && (smag4[41:8] != '0);
      lbig_m1 <= !sneg4 && (smag4[41:8] != '0);
      neg_m1  <= sneg4;
      sa_m1   <= smag4[7:0];
      lbm1    <= lbp4;
      prod_m2 <= row_even[TargetWidth-1:0] + row_odd[TargetWidth-1:0];
      rbig_m2 <= rbig_m1;
      lbig_m2 <= lbig_m1;
      neg_m2  <= neg_m1;
      sa_m2   <= sa_m1;
      lbm2    <= lbm1;
      // shift both ways and scale the limit
      tshr_h1 <= prod_m2 >> sa_m2;
      tshl_h1 <= prod_m2 << sa_m2;
      lsh_h1  <= limit_q >> sa_m2;
      prod_h1 <= prod_m2;
      rbig_h1 <= rbig_m2;
      lbig_h1 <= lbig_m2;
      neg_h1  <= neg_m2;
      lbh1    <= lbm2;
      // choose shifted target, saturating at the limit on overflow
      if (neg_h1) begin
        tgt_h2 <= tshr_h1;
      end else if (lbig_h1 || (prod_h1 > lsh_h1)) begin
        tgt_h2 <= limit_q;
      end else begin
        tgt_h2 <= tshl_h1;
      end
      rbig_h2 <= rbig_h1;
      lbh2    <= lbh1;
      // clamp to [1, limit]
      if (tgt_h2 == '0) begin
        tgt_h3 <= {{(TargetWidth-1){1'b0}}, 1'b1};
      end else if (tgt_h2 > limit_q) begin
        tgt_h3 <= limit_q;
      end else begin
        tgt_h3 <= tgt_h2;
      end
      rbig_h3 <= rbig_h2;
      lbh3    <= lbh2;
      // compact encode
      for (int i = 0; i < LimbCount; i++) begin
        nz_e1[i]  <= tgt_h3[32*i +: 32] != 32'd0;
        pos_e1[i] <= pos_c[i];
      end
      tgt_e1  <= tgt_h3;
      rbig_e1 <= rbig_h3;
      lbe1    <= lbh3;
      size_e2 <= 6'((nbits + 9'd7) >> 3);
      tgt_e2  <= tgt_e1;
      rbig_e2 <= rbig_e1;
      lbe2    <= lbe1;
      c_e3    <= c_pick;
      size_e3 <= size_e2;
      rbig_e3 <= rbig_e2;
      lbe3    <= lbe2;
      next_bits <= bits_fin;
    end
  end

endmodule

// ----- hdl/asert_chk.sv -----
`timescale 1ns / 1ps
// Port-level checks for asert_next_target, bound to the top level.
// Depends on asert_next_target's ports only.
module asert_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] next_bits
);

  // a held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_bits))
    else $error("result word changed while stalled");

  // a blocked result backs up to the request side
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result blocked");

  // an empty output leaves the request side open
  a_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("request stalled with empty output");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind asert_next_target asert_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .next_bits (next_bits)
);
